// File: rtl/core/mst_pkg.sv
// Package of the multi-slot software timer.
// Holds command and result codes, sequencer states and the slot update struct.
// No dependencies.
`default_nettype none

package mst_pkg;

    // Command codes of a request
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_ARM    = 2'd1;
    localparam logic [1:0] CMD_CANCEL = 2'd2;

    // Result kinds
    localparam logic KIND_ACK     = 1'b0;
    localparam logic KIND_EXPIRED = 1'b1;

    localparam int CNT_W  = 32;
    localparam int SLOT_W = 4;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    // Outcome of one slot visit during a tick walk
    typedef struct packed {
        logic              we;
        logic              fire;
        logic              clr_active;
        logic [CNT_W-1:0]  remaining;
    } t_upd;

endpackage

`default_nettype wire

// File: rtl/core/mst_cmd_if.sv
// Request channel of the multi-slot software timer.
// Depends on mst_pkg for field widths.
`default_nettype none

interface mst_cmd_if
    import mst_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  interval_ms;
    logic              periodic;
    logic              has_handler;

    modport source (output valid, command, slot, interval_ms, periodic, has_handler,
                    input ready);
    modport sink   (input valid, command, slot, interval_ms, periodic, has_handler,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/core/mst_res_if.sv
// Result channel of the multi-slot software timer.
// Depends on mst_pkg for field widths.
`default_nettype none

interface mst_res_if
    import mst_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [SLOT_W-1:0] fired_slot;
    logic              accepted;
    logic              last;

    modport source (output valid, kind, fired_slot, accepted, last, input ready);
    modport sink   (input valid, kind, fired_slot, accepted, last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/multi_slot_software_timer.sv
// Multi-slot software timer: a bank of countdown slots, one-shot or periodic.
// Request channel i_cmd carries tick, arm and cancel; result channel o_res
// carries expiry events and one acknowledge per request (last set on it).
// Arm and cancel update the slot in the accept cycle and place the
// acknowledge in the output register, visible in the next cycle.
// A tick walks all SLOT_COUNT slots through one decrement/compare unit,
// one slot per cycle while the output register is free, reading counts
// from a RAM one slot ahead; expiries leave in ascending slot order, then
// the closing acknowledge of the tick.
// i_cmd.ready is high only while idle with a free output register, so one
// request is handled at a time.
// When the receiver stalls, the walk holds in place until the output
// register frees; no result is lost or repeated.
// Reset clears all slot active and periodic flags and the output valid flag;
// interval and count storage is written by arm before any use.
// Depends on mst_pkg, mst_cmd_if, mst_res_if, mst_ram and mst_dec_unit.
`default_nettype none

module multi_slot_software_timer
    import mst_pkg::*;
#(
    parameter int SLOT_COUNT = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mst_cmd_if.sink   i_cmd,
    mst_res_if.source o_res
);
    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CMP_W = ((IDX_W + 1) > SLOT_W) ? (IDX_W + 1) : (SLOT_W + 1);

    t_state r_state, n_state;

    logic [SLOT_COUNT-1:0] r_active, n_active;
    logic [SLOT_COUNT-1:0] r_periodic, n_periodic;

    logic [IDX_W:0]   r_rd_cnt, n_rd_cnt;
    logic [IDX_W-1:0] r_proc_idx, n_proc_idx;
    logic             r_proc_valid, n_proc_valid;

    logic              r_out_valid, n_out_valid;
    logic              r_out_kind, n_out_kind;
    logic [SLOT_W-1:0] r_out_slot, n_out_slot;
    logic              r_out_acc, n_out_acc;
    logic              r_out_last, n_out_last;

    logic                 out_free;
    logic                 accept;
    logic                 rd_more;
    logic                 walk_done;
    logic                 slot_ok;
    logic                 arm_ok;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [2*CNT_W-1:0]   ram_wdata;
    logic                 ram_re;
    logic [2*CNT_W-1:0]   ram_rdata;
    t_upd                 upd;

    assign out_free    = !r_out_valid || o_res.ready;
    assign i_cmd.ready = (r_state == ST_IDLE) && out_free;
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign rd_more     = (r_rd_cnt < (IDX_W+1)'(SLOT_COUNT));
    assign walk_done   = !rd_more && !r_proc_valid;
    assign slot_ok     = (CMP_W'(i_cmd.slot) < CMP_W'(SLOT_COUNT));
    assign arm_ok      = (i_cmd.interval_ms != '0) && i_cmd.has_handler && slot_ok;

    // Interval in the upper half, remaining count in the lower half
    mst_ram #(
        .WIDTH (2*CNT_W),
        .DEPTH (SLOT_COUNT),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_cnt[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    mst_dec_unit u_dec (
        .i_active    (r_active[r_proc_idx]),
        .i_periodic  (r_periodic[r_proc_idx]),
        .i_interval  (ram_rdata[2*CNT_W-1:CNT_W]),
        .i_remaining (ram_rdata[CNT_W-1:0]),
        .o_upd       (upd)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_cmd.command == CMD_TICK)) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (out_free && walk_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath control and results
    always_comb begin
        n_active     = r_active;
        n_periodic   = r_periodic;
        n_rd_cnt     = r_rd_cnt;
        n_proc_idx   = r_proc_idx;
        n_proc_valid = r_proc_valid;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_kind   = r_out_kind;
        n_out_slot   = r_out_slot;
        n_out_acc    = r_out_acc;
        n_out_last   = r_out_last;
        ram_we       = 1'b0;
        ram_waddr    = r_proc_idx;
        ram_wdata    = {ram_rdata[2*CNT_W-1:CNT_W], upd.remaining};
        ram_re       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_ACK;
                    n_out_slot  = i_cmd.slot;
                    n_out_acc   = 1'b1;
                    n_out_last  = 1'b1;
                    n_rd_cnt    = '0;
                    n_proc_valid = 1'b0;
                    case (i_cmd.command)
                        CMD_TICK: begin
                            // Walk starts; acknowledge comes at its end
                            n_out_valid = r_out_valid && !o_res.ready;
                        end
                        CMD_ARM: begin
                            n_out_acc = arm_ok;
                            if (arm_ok) begin
                                ram_we    = 1'b1;
                                ram_waddr = IDX_W'(i_cmd.slot);
                                ram_wdata = {i_cmd.interval_ms, i_cmd.interval_ms};
                                n_active[IDX_W'(i_cmd.slot)]   = 1'b1;
                                n_periodic[IDX_W'(i_cmd.slot)] = i_cmd.periodic;
                            end
                        end
                        CMD_CANCEL: begin
                            if (slot_ok) begin
                                n_active[IDX_W'(i_cmd.slot)] = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK: begin
                if (out_free) begin
                    // Read next slot while the previous one is evaluated
                    ram_re       = rd_more;
                    n_proc_valid = rd_more;
                    n_proc_idx   = r_rd_cnt[IDX_W-1:0];
                    if (rd_more) begin
                        n_rd_cnt = r_rd_cnt + (IDX_W+1)'(1);
                    end
                    if (r_proc_valid) begin
                        ram_we = upd.we;
                        if (upd.clr_active) begin
                            n_active[r_proc_idx] = 1'b0;
                        end
                        if (upd.fire) begin
                            n_out_valid = 1'b1;
                            n_out_kind  = KIND_EXPIRED;
                            n_out_slot  = SLOT_W'(r_proc_idx);
                            n_out_acc   = 1'b1;
                            n_out_last  = 1'b0;
                        end
                    end else if (walk_done) begin
                        // Close the tick with its acknowledge
                        n_out_valid = 1'b1;
                        n_out_kind  = KIND_ACK;
                        n_out_slot  = '0;
                        n_out_acc   = 1'b1;
                        n_out_last  = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_active     <= '0;
            r_periodic   <= '0;
            r_rd_cnt     <= '0;
            r_proc_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_active     <= n_active;
            r_periodic   <= n_periodic;
            r_rd_cnt     <= n_rd_cnt;
            r_proc_valid <= n_proc_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_proc_idx <= n_proc_idx;
        r_out_kind <= n_out_kind;
        r_out_slot <= n_out_slot;
        r_out_acc  <= n_out_acc;
        r_out_last <= n_out_last;
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.kind       = r_out_kind;
    assign o_res.fired_slot = r_out_slot;
    assign o_res.accepted   = r_out_acc;
    assign o_res.last       = r_out_last;
endmodule

`default_nettype wire

// File: rtl/core/mst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

`default_nettype wire

// File: rtl/core/mst_dec_unit.sv
// Shared decrement and compare unit: evaluates one slot during a tick walk.
// Depends on mst_pkg for the t_upd struct.
`default_nettype none

module mst_dec_unit
    import mst_pkg::*;
(
    input  wire logic             i_active,
    input  wire logic             i_periodic,
    input  wire logic [CNT_W-1:0] i_interval,
    input  wire logic [CNT_W-1:0] i_remaining,
    output t_upd                  o_upd
);
    logic             live;
    logic             hit;
    logic [CNT_W-1:0] dec;

    // Count down live slots; reload or drop on reaching zero
    always_comb begin
        live                 = i_active && (i_remaining != '0);
        dec                  = i_remaining - CNT_W'(1);
        hit                  = live && (dec == '0);
        o_upd.we             = live;
        o_upd.fire           = hit;
        o_upd.clr_active     = hit && !i_periodic;
        o_upd.remaining      = (hit && i_periodic) ? i_interval : dec;
    end
endmodule

`default_nettype wire
